>>> rtl/cascaded_state_variable_filter_defines.svh
// Assertion helpers used by the checker file of this block.
`ifndef CASCADED_STATE_VARIABLE_FILTER_DEFINES_SVH
`define CASCADED_STATE_VARIABLE_FILTER_DEFINES_SVH

// Property checked on every rising edge while reset is released.
`define CSVF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define CSVF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/csvf_pkg.sv
package csvf_pkg;

  // Default widths of the sample and integrator words.
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int STATE_WIDTH_DEF  = 32;

  // Register field widths.
  localparam int MODE_W  = 3;
  localparam int COEF_W  = 18;
  localparam int DRIVE_W = 24;
  localparam int INV_W   = 17;

  // Coefficient operand of the shared multiplier (widest register field).
  localparam int MUL_C_W = DRIVE_W;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TWO   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_A1    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_A2    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_A3    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_K     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_INV   = 3'd7;

  // Filter response codes; unused codes behave as peak.
  localparam logic [MODE_W-1:0] MODE_LP    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HP    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_NOTCH = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PEAK  = 3'd4;

  // Register reset values.
  localparam logic [MODE_W-1:0]  RST_MODE  = MODE_LP;
  localparam logic               RST_TWO   = 1'b1;
  localparam logic [COEF_W-1:0]  RST_A1    = 18'd65536;
  localparam logic [COEF_W-1:0]  RST_A2    = 18'd0;
  localparam logic [COEF_W-1:0]  RST_A3    = 18'd0;
  localparam logic [COEF_W-1:0]  RST_K     = 18'd65536;
  localparam logic [DRIVE_W-1:0] RST_DRIVE = 24'd65536;
  localparam logic [INV_W-1:0]   RST_INV   = 17'd65536;

  // Unity drive in Q8.16 and unity sample level in 20 fraction bits.
  localparam logic [DRIVE_W-1:0] DRIVE_UNITY = 24'd65536;
  localparam int FRAC_ONE = 1048576;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic               two_stage;
    logic [COEF_W-1:0]  a1;
    logic [COEF_W-1:0]  a2;
    logic [COEF_W-1:0]  a3;
    logic [COEF_W-1:0]  k;
    logic [DRIVE_W-1:0] drive;
    logic [INV_W-1:0]   inv;
  } cfg_t;

endpackage

>>> rtl/csvf_regs.sv
module csvf_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [csvf_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [csvf_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [csvf_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output csvf_pkg::cfg_t                    cfg
);
  import csvf_pkg::*;

  cfg_t                 cfg_r;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register writes, masked to each field's width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= RST_MODE;
      cfg_r.two_stage <= RST_TWO;
      cfg_r.a1        <= RST_A1;
      cfg_r.a2        <= RST_A2;
      cfg_r.a3        <= RST_A3;
      cfg_r.k         <= RST_K;
      cfg_r.drive     <= RST_DRIVE;
      cfg_r.inv       <= RST_INV;
    end else if (wr_en) begin
      case (idx)
        REG_MODE:  cfg_r.mode      <= pwdata[MODE_W-1:0];
        REG_TWO:   cfg_r.two_stage <= pwdata[0];
        REG_A1:    cfg_r.a1        <= pwdata[COEF_W-1:0];
        REG_A2:    cfg_r.a2        <= pwdata[COEF_W-1:0];
        REG_A3:    cfg_r.a3        <= pwdata[COEF_W-1:0];
        REG_K:     cfg_r.k         <= pwdata[COEF_W-1:0];
        REG_DRIVE: cfg_r.drive     <= pwdata[DRIVE_W-1:0];
        REG_INV:   cfg_r.inv       <= pwdata[INV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back, zero extended.
  always_comb begin
    case (idx)
      REG_MODE:  prdata = CFG_DATA_W'(cfg_r.mode);
      REG_TWO:   prdata = CFG_DATA_W'(cfg_r.two_stage);
      REG_A1:    prdata = CFG_DATA_W'(cfg_r.a1);
      REG_A2:    prdata = CFG_DATA_W'(cfg_r.a2);
      REG_A3:    prdata = CFG_DATA_W'(cfg_r.a3);
      REG_K:     prdata = CFG_DATA_W'(cfg_r.k);
      REG_DRIVE: prdata = CFG_DATA_W'(cfg_r.drive);
      REG_INV:   prdata = CFG_DATA_W'(cfg_r.inv);
      default:   prdata = '0;
    endcase
  end

endmodule

>>> rtl/csvf_mul.sv
module csvf_mul #(
  parameter int A_WIDTH = csvf_pkg::STATE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [A_WIDTH-1:0]         a,
  input  logic [csvf_pkg::MUL_C_W-1:0]      c,
  output logic signed [A_WIDTH+8:0]         p_r
);
  import csvf_pkg::*;

  localparam int PROD_W = A_WIDTH + MUL_C_W + 1;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;

  // Signed value times unsigned coefficient, rounded half up to 16 fewer
  // fraction bits.
  assign prod = a * $signed({1'b0, c});
  assign rnd  = prod + PROD_W'(32768);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= rnd[PROD_W-1:16];
    end
  end

endmodule

>>> rtl/csvf_seq.sv
module csvf_seq #(
  parameter int SAMPLE_WIDTH = csvf_pkg::SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH  = csvf_pkg::STATE_WIDTH_DEF,
  parameter int A_WIDTH      = csvf_pkg::STATE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  csvf_pkg::cfg_t                    cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_action,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [SAMPLE_WIDTH-1:0]           out_sample,
  output logic                              out_sat,
  output logic                              mul_en,
  output logic signed [A_WIDTH-1:0]         mul_a,
  output logic [csvf_pkg::MUL_C_W-1:0]      mul_c,
  input  logic signed [A_WIDTH+8:0]         mul_p
);
  import csvf_pkg::*;

  localparam int ACC_W = A_WIDTH + 12;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DRV  = 4'd1;
  localparam logic [3:0] ST_XIN  = 4'd2;
  localparam logic [3:0] ST_V3   = 4'd3;
  localparam logic [3:0] ST_V1A  = 4'd4;
  localparam logic [3:0] ST_V1B  = 4'd5;
  localparam logic [3:0] ST_V2A  = 4'd6;
  localparam logic [3:0] ST_V2B  = 4'd7;
  localparam logic [3:0] ST_Y    = 4'd8;
  localparam logic [3:0] ST_CLIP = 4'd9;
  localparam logic [3:0] ST_FIN  = 4'd10;

  // Saturation bounds, held at accumulator width.
  localparam logic signed [ACC_W-1:0] ST_MAX =
    {{(ACC_W-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [ACC_W-1:0] SM_MAX =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SM_MIN = ~SM_MAX;
  localparam logic signed [STATE_WIDTH-1:0] ONE_P = STATE_WIDTH'(FRAC_ONE);
  localparam logic signed [STATE_WIDTH-1:0] ONE_N = STATE_WIDTH'(-FRAC_ONE);

  logic [3:0]                     state_r;
  logic [3:0]                     state_nxt;
  logic                           stg_r;
  logic                           out_valid_r;
  logic signed [STATE_WIDTH-1:0]  int0_r;
  logic signed [STATE_WIDTH-1:0]  int1_r;
  logic signed [STATE_WIDTH-1:0]  int2_r;
  logic signed [STATE_WIDTH-1:0]  int3_r;
  logic signed [SAMPLE_WIDTH-1:0] smp_r;
  logic signed [STATE_WIDTH-1:0]  x_r;
  logic signed [STATE_WIDTH-1:0]  v3_r;
  logic signed [STATE_WIDTH-1:0]  v1_r;
  logic signed [STATE_WIDTH-1:0]  v2_r;
  logic signed [STATE_WIDTH-1:0]  y_r;
  logic signed [ACC_W-1:0]        acc_r;
  logic [SAMPLE_WIDTH-1:0]        out_sample_r;
  logic                           out_sat_r;

  logic signed [STATE_WIDTH-1:0]  s1;
  logic signed [STATE_WIDTH-1:0]  s2;
  logic signed [STATE_WIDTH-1:0]  s1_new;
  logic signed [STATE_WIDTH-1:0]  s2_new;
  logic signed [STATE_WIDTH-1:0]  load_val;
  logic signed [STATE_WIDTH-1:0]  yc;
  logic signed [ACC_W-1:0]        pe;
  logic signed [ACC_W-1:0]        y_full;
  logic signed [ACC_W-1:0]        xe;
  logic signed [ACC_W-1:0]        v1e;
  logic signed [ACC_W-1:0]        v2e;
  logic                           clip_en;
  logic                           out_load;

  function automatic logic signed [STATE_WIDTH-1:0] sat_st(input logic signed [ACC_W-1:0] v);
    if (v > ST_MAX) begin
      sat_st = ST_MAX[STATE_WIDTH-1:0];
    end else if (v < ST_MIN) begin
      sat_st = ST_MIN[STATE_WIDTH-1:0];
    end else begin
      sat_st = v[STATE_WIDTH-1:0];
    end
  endfunction

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_sat    = out_sat_r;
  assign out_load   = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // Integrator pair of the stage in progress.
  assign s1 = stg_r ? int2_r : int0_r;
  assign s2 = stg_r ? int3_r : int1_r;

  assign pe       = ACC_W'(mul_p);
  assign xe       = ACC_W'(x_r);
  assign v1e      = ACC_W'(v1_r);
  assign v2e      = ACC_W'(v2_r);
  assign s1_new   = sat_st((v1e <<< 1) - ACC_W'(s1));
  assign s2_new   = sat_st((v2e <<< 1) - ACC_W'(s2));
  assign load_val = sat_st(ACC_W'(in_sample));

  // Stage output for the selected response; the multiplier holds k*v1.
  always_comb begin
    case (cfg.mode)
      MODE_LP:    y_full = v2e;
      MODE_BP:    y_full = v1e;
      MODE_HP:    y_full = xe - pe - v2e;
      MODE_NOTCH: y_full = xe - pe;
      default:    y_full = xe + (v1e <<< 1) - pe;
    endcase
  end

  // Hard clip to unity when the drive is above unity.
  assign clip_en = (cfg.drive > DRIVE_UNITY);
  always_comb begin
    if (clip_en && (y_r > ONE_P)) begin
      yc = ONE_P;
    end else if (clip_en && (y_r < ONE_N)) begin
      yc = ONE_N;
    end else begin
      yc = y_r;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_c  = '0;
    case (state_r)
      ST_DRV: begin
        mul_en = 1'b1;
        mul_a  = A_WIDTH'(smp_r);
        mul_c  = MUL_C_W'(cfg.drive);
      end
      ST_V3: begin
        mul_en = 1'b1;
        mul_a  = A_WIDTH'(s1);
        mul_c  = MUL_C_W'(cfg.a1);
      end
      ST_V1A: begin
        mul_en = 1'b1;
        mul_a  = A_WIDTH'(v3_r);
        mul_c  = MUL_C_W'(cfg.a2);
      end
      ST_V1B: begin
        mul_en = 1'b1;
        mul_a  = A_WIDTH'(s1);
        mul_c  = MUL_C_W'(cfg.a2);
      end
      ST_V2A: begin
        mul_en = 1'b1;
        mul_a  = A_WIDTH'(v3_r);
        mul_c  = MUL_C_W'(cfg.a3);
      end
      ST_V2B: begin
        mul_en = 1'b1;
        mul_a  = A_WIDTH'(v1_r);
        mul_c  = MUL_C_W'(cfg.k);
      end
      ST_CLIP: begin
        mul_en = 1'b1;
        mul_a  = A_WIDTH'(yc);
        mul_c  = MUL_C_W'(cfg.inv);
      end
      default: begin
      end
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    case (state_r)
      ST_IDLE: state_nxt = (in_valid && !in_action) ? ST_DRV : ST_IDLE;
      ST_DRV:  state_nxt = ST_XIN;
      ST_XIN:  state_nxt = ST_V3;
      ST_V3:   state_nxt = ST_V1A;
      ST_V1A:  state_nxt = ST_V1B;
      ST_V1B:  state_nxt = ST_V2A;
      ST_V2A:  state_nxt = ST_V2B;
      ST_V2B:  state_nxt = ST_Y;
      ST_Y:    state_nxt = (!stg_r && cfg.two_stage) ? ST_V3 : ST_CLIP;
      ST_CLIP: state_nxt = ST_FIN;
      ST_FIN:  state_nxt = out_load ? ST_IDLE : ST_FIN;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state and integrators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stg_r       <= 1'b0;
      out_valid_r <= 1'b0;
      int0_r      <= '0;
      int1_r      <= '0;
      int2_r      <= '0;
      int3_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid && in_action) begin
            int0_r <= load_val;
            int1_r <= load_val;
            int2_r <= load_val;
            int3_r <= load_val;
          end
        end
        ST_XIN: stg_r <= 1'b0;
        ST_V2A: begin
          if (stg_r) begin
            int2_r <= s1_new;
          end else begin
            int0_r <= s1_new;
          end
        end
        ST_Y: begin
          if (stg_r) begin
            int3_r <= s2_new;
          end else begin
            int1_r <= s2_new;
          end
          if (!stg_r && cfg.two_stage) begin
            stg_r <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (in_valid && !in_action) smp_r <= in_sample;
      ST_XIN:  x_r  <= sat_st(pe);
      ST_V3:   v3_r <= sat_st(xe - ACC_W'(s2));
      ST_V1A:  acc_r <= pe;
      ST_V1B:  v1_r <= sat_st(acc_r + pe);
      ST_V2A:  acc_r <= ACC_W'(s2) + pe;
      ST_V2B:  v2_r <= sat_st(acc_r + pe);
      ST_Y: begin
        x_r <= sat_st(y_full);
        y_r <= sat_st(y_full);
      end
      ST_FIN: begin
        if (out_load) begin
          if (pe > SM_MAX) begin
            out_sample_r <= SM_MAX[SAMPLE_WIDTH-1:0];
            out_sat_r    <= 1'b1;
          end else if (pe < SM_MIN) begin
            out_sample_r <= SM_MIN[SAMPLE_WIDTH-1:0];
            out_sat_r    <= 1'b1;
          end else begin
            out_sample_r <= pe[SAMPLE_WIDTH-1:0];
            out_sat_r    <= 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/cascaded_state_variable_filter.sv
// A filtered word is offered once the drive, input, stage and clip steps are
// done, the stage steps running twice with two stages; a load word gives no
// result. A new word is taken only after the last result enters the output
// register; the one multiplier serves all twelve or seven products in turn.
// Reset (rst_n low, synchronous) clears the integrators, loads the register
// defaults and empties the output register.
module cascaded_state_variable_filter #(
  parameter int SAMPLE_WIDTH = csvf_pkg::SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH  = csvf_pkg::STATE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // Fields from bit 0: sample_in.
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     in_tdata,
  // Fields from bit 0: action.
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // Fields from bit 0: sample_out.
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     out_tdata,
  // Fields from bit 0: saturated.
  output logic                                  out_tuser,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [csvf_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [csvf_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [csvf_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                  cfg_pready
);
  import csvf_pkg::*;

  localparam int DATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int A_WIDTH = (SAMPLE_WIDTH > STATE_WIDTH) ? SAMPLE_WIDTH : STATE_WIDTH;

  cfg_t                       cfg;
  logic                       mul_en;
  logic signed [A_WIDTH-1:0]  mul_a;
  logic [MUL_C_W-1:0]         mul_c;
  logic signed [A_WIDTH+8:0]  mul_p;
  logic [SAMPLE_WIDTH-1:0]    out_sample;

  // Configuration registers.
  csvf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Shared multiply and round unit.
  csvf_mul #(
    .A_WIDTH (A_WIDTH)
  ) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .c   (mul_c),
    .p_r (mul_p)
  );

  // Sequencer, integrators and output register.
  csvf_seq #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .STATE_WIDTH  (STATE_WIDTH),
    .A_WIDTH      (A_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_action  (in_tuser),
    .in_sample  ($signed(in_tdata[SAMPLE_WIDTH-1:0])),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (out_sample),
    .out_sat    (out_tuser),
    .mul_en     (mul_en),
    .mul_a      (mul_a),
    .mul_c      (mul_c),
    .mul_p      (mul_p)
  );

  assign out_tdata = DATA_W'(out_sample);

endmodule

>>> rtl/csvf_checker.sv
`include "cascaded_state_variable_filter_defines.svh"

module csvf_checker #(
  parameter int SAMPLE_WIDTH = csvf_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [((SAMPLE_WIDTH+7)/8)*8-1:0] out_tdata,
  input logic                              out_tuser
);
  localparam logic [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // A stalled result word holds its data.
  `CSVF_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result word changed while stalled")

  // A filter word keeps the block busy for the following cycle.
  `CSVF_ASSERT(a_busy, in_tvalid && in_tready && !in_tuser |=> !in_tready, "ready after a filter word")

  // A load word leaves the block ready for the next word.
  `CSVF_ASSERT(a_load_ready, in_tvalid && in_tready && in_tuser |=> in_tready, "busy after a load word")

  // A saturated result sits at one of the two rails.
  `CSVF_ASSERT(a_sat_rail, out_tvalid && out_tuser |-> (out_tdata[SAMPLE_WIDTH-1:0] == SMP_MAX) || (out_tdata[SAMPLE_WIDTH-1:0] == SMP_MIN), "saturated flag off the rails")

  // Reset leaves the block ready with no result pending.
  `CSVF_ASSERT_ALWAYS(a_reset, !rst_n |=> in_tready && !out_tvalid, "bad state after reset")

endmodule

bind cascaded_state_variable_filter csvf_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_csvf_checker (.*);
